// ===== sv/asidga_pkg.sv =====
// Shared types, constants and helpers for the ASID generation allocator.
// No dependencies; used by the map RAM and the top level.
package asidga_pkg;

  localparam int unsigned MaxCpus     = 8;
  localparam int unsigned MaxAsidBits = 16;
  localparam int unsigned NarrowBits  = 8;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned BitIdxBits  = 6;
  localparam int unsigned HintBits    = 17;

  // Register indexes (address bit 2 of the config port)
  localparam logic RegAsidWide = 1'b0;
  localparam logic RegCpuCount = 1'b1;

  typedef struct packed {
    logic [2:0]  cpu_index;
    logic [63:0] process_ctx;
  } asidga_req_t;

  typedef struct packed {
    logic [63:0] new_ctx;
    logic [15:0] asid_number;
    logic        local_flush;
    logic        rolled_over;
  } asidga_rsp_t;

  // Lowest set bit of a map word: {found, index}
  function automatic logic [BitIdxBits:0] first_one64(input logic [WordBits-1:0] v);
    logic [BitIdxBits:0] r;
    r = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BitIdxBits'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/asid_generation_allocator.sv =====
// ASID allocator with generation rollover. Takes one context-switch request
// (CPU, packed context) at a time and returns one response. The fast path
// (live CPU, current generation) goes from evaluation straight to the
// response; a kept or reserved number passes a finish step, and a kept one
// first reads its old map word. A bitmap search reads one 64-bit map word
// per cycle from the hint, pool/64 + 1 reads at most. A rollover adds a
// clearing pass over the map, then a map read and write per scanned CPU
// that carries a number forward and a final step, then searches again. The
// map RAM has a single read port. After reset, and after any write to the
// width register, the block clears the map one word at a time (1024 words
// wide, 4 narrow) and accepts no request meanwhile; config writes are
// taken at any time.
module asid_generation_allocator import asidga_pkg::*; #(
  parameter int unsigned MAX_CPUS      = MaxCpus,
  parameter int unsigned MAX_ASID_BITS = MaxAsidBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  asidga_req_t req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output asidga_rsp_t rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int unsigned NCW = $clog2(MAX_CPUS + 1);
  localparam int unsigned WI  = MAX_ASID_BITS - BitIdxBits;
  localparam logic [63:0] WideMask   = (64'd1 << MAX_ASID_BITS) - 64'd1;
  localparam logic [63:0] NarrowMask = (64'd1 << NarrowBits) - 64'd1;
  localparam logic [WI-1:0] NarrowWordMask = WI'((1 << (NarrowBits - BitIdxBits)) - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_OLD  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_CLR  = 4'd4;
  localparam logic [3:0] S_RCLR = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_RFIN = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // control state
  logic [3:0]          state_q, state_d;
  logic                asid_wide_q, asid_wide_d;
  logic [3:0]          cpu_count_q, cpu_count_d;
  logic [63:0]         gen_q, gen_d;
  logic [HintBits-1:0] hint_q, hint_d;
  logic [63:0]         active_q [MAX_CPUS];
  logic [63:0]         active_d [MAX_CPUS];
  logic [63:0]         reserved_q [MAX_CPUS];
  logic [63:0]         reserved_d [MAX_CPUS];
  logic [MAX_CPUS-1:0] flush_q, flush_d;
  logic [WI-1:0]       clr_q, clr_d;
  logic [WI-1:0]       scan_w_q, scan_w_d;
  logic [WI:0]         scan_k_q, scan_k_d;
  logic [NCW-1:0]      ro_cpu_q, ro_cpu_d;
  logic                rsp_valid_q, rsp_valid_d;

  // payload
  asidga_req_t         in_q, in_d;
  asidga_rsp_t         rsp_q, rsp_d;
  logic [63:0]         res_ctx_q, res_ctx_d;
  logic                res_flush_q, res_flush_d;
  logic                res_roll_q, res_roll_d;
  logic [63:0]         ro_a_q, ro_a_d;

  // map RAM port
  logic                mem_we;
  logic [WI-1:0]       mem_waddr, mem_raddr;
  logic [WordBits-1:0] mem_wdata, mem_rdata;

  asidga_map_ram #(.AW(WI)) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // width-dependent masks
  logic [63:0]   mask64, pool64;
  logic [WI-1:0] wmask;
  logic [WI:0]   nwords;
  assign mask64 = asid_wide_q ? WideMask : NarrowMask;
  assign pool64 = mask64 + 64'd1;
  assign wmask  = asid_wide_q ? {WI{1'b1}} : NarrowWordMask;
  assign nwords = {1'b0, wmask} + 1'b1;

  // CPUs scanned, clamped to MAX_CPUS
  logic [NCW-1:0] nc;
  always_comb begin
    if (int'(cpu_count_q) > int'(MAX_CPUS)) begin
      nc = NCW'(MAX_CPUS);
    end else begin
      nc = NCW'(cpu_count_q);
    end
  end

  // request CPU taken modulo MAX_CPUS
  logic [3:0]    cpu_t;
  logic [CW-1:0] cpu_idx, sel;
  always_comb begin
    cpu_t = {1'b0, in_q.cpu_index};
    for (int k = 0; k < 8; k++) begin
      if (int'(cpu_t) >= int'(MAX_CPUS)) begin
        cpu_t = cpu_t - 4'(MAX_CPUS);
      end
    end
    cpu_idx = CW'(cpu_t);
  end

  // one CPU slot is looked at per cycle: the rollover walker or the requester
  assign sel = (state_q == S_RRD) ? ro_cpu_q[CW-1:0] : cpu_idx;

  // context decode
  logic [63:0] ctx, ctx_hi, renewed, old_asid;
  logic [BitIdxBits-1:0] old_bit;
  assign ctx      = in_q.process_ctx;
  assign ctx_hi   = ctx & ~mask64;
  assign old_asid = ctx & mask64;
  assign renewed  = gen_q | old_asid;
  assign old_bit  = old_asid[BitIdxBits-1:0];

  // reservation hits, all scanned CPUs in parallel
  logic [MAX_CPUS-1:0] hit_vec;
  always_comb begin
    for (int c = 0; c < MAX_CPUS; c++) begin
      hit_vec[c] = (c < int'(nc)) && (reserved_q[c] == ctx);
    end
  end

  // free-bit search in the current map word
  logic [WordBits-1:0]   low_mask, elig, free_bits;
  logic [BitIdxBits:0]   ffo;
  logic [63:0]           found_a;
  assign low_mask  = (64'd1 << hint_q[BitIdxBits-1:0]) - 64'd1;
  always_comb begin
    if (scan_k_q == '0) begin
      elig = ~low_mask;
    end else if (scan_k_q == nwords) begin
      elig = low_mask;
    end else begin
      elig = '1;
    end
  end
  assign free_bits = ~mem_rdata & elig;
  assign ffo       = first_one64(free_bits);
  assign found_a   = 64'({scan_w_q, ffo[BitIdxBits-1:0]});

  // rollover carry-forward value of the walked CPU
  logic [63:0] carry_a;
  assign carry_a = (active_q[sel] != 64'd0) ? active_q[sel] : reserved_q[sel];

  logic cfg_we;
  assign cfg_we = psel & penable & pwrite & pready;

  // sequencer
  always_comb begin
    state_d     = state_q;
    asid_wide_d = asid_wide_q;
    cpu_count_d = cpu_count_q;
    gen_d       = gen_q;
    hint_d      = hint_q;
    active_d    = active_q;
    reserved_d  = reserved_q;
    flush_d     = flush_q;
    clr_d       = clr_q;
    scan_w_d    = scan_w_q;
    scan_k_d    = scan_k_q;
    ro_cpu_d    = ro_cpu_q;
    rsp_valid_d = rsp_valid_q;
    in_d        = in_q;
    rsp_d       = rsp_q;
    res_ctx_d   = res_ctx_q;
    res_flush_d = res_flush_q;
    res_roll_d  = res_roll_q;
    ro_a_d      = ro_a_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q) inside
      S_CLR, S_RCLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? 64'd1 : 64'd0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == wmask) begin
          state_d  = (state_q == S_CLR) ? S_IDLE : S_RRD;
          ro_cpu_d = '0;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          in_d    = req_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        res_roll_d = 1'b0;
        if (active_q[sel] != 64'd0 && ctx_hi == gen_q) begin
          // fast path
          active_d[sel] = ctx;
          res_ctx_d     = ctx;
          res_flush_d   = 1'b0;
          state_d       = S_OUT;
        end else if (ctx_hi == gen_q) begin
          res_ctx_d = ctx;
          state_d   = S_FIN;
        end else if (ctx != 64'd0) begin
          if (|hit_vec) begin
            for (int c = 0; c < MAX_CPUS; c++) begin
              if (hit_vec[c]) begin
                reserved_d[c] = renewed;
              end
            end
            res_ctx_d = renewed;
            state_d   = S_FIN;
          end else begin
            mem_raddr = old_asid[MAX_ASID_BITS-1:BitIdxBits];
            state_d   = S_OLD;
          end
        end else begin
          mem_raddr = hint_q[MAX_ASID_BITS-1:BitIdxBits] & wmask;
          scan_w_d  = hint_q[MAX_ASID_BITS-1:BitIdxBits] & wmask;
          scan_k_d  = '0;
          state_d   = S_SCAN;
        end
      end
      S_OLD: begin
        if (!mem_rdata[old_bit]) begin
          // old number still free: keep it
          mem_we    = 1'b1;
          mem_waddr = old_asid[MAX_ASID_BITS-1:BitIdxBits];
          mem_wdata = mem_rdata | (64'd1 << old_bit);
          res_ctx_d = renewed;
          state_d   = S_FIN;
        end else begin
          mem_raddr = hint_q[MAX_ASID_BITS-1:BitIdxBits] & wmask;
          scan_w_d  = hint_q[MAX_ASID_BITS-1:BitIdxBits] & wmask;
          scan_k_d  = '0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ffo[BitIdxBits]) begin
          mem_we    = 1'b1;
          mem_waddr = scan_w_q;
          mem_wdata = mem_rdata | (64'd1 << ffo[BitIdxBits-1:0]);
          hint_d    = HintBits'(found_a + 64'd1);
          res_ctx_d = gen_q | found_a;
          state_d   = S_FIN;
        end else if (scan_k_q == nwords) begin
          // pool full: roll over
          res_roll_d = 1'b1;
          clr_d      = '0;
          state_d    = S_RCLR;
        end else begin
          scan_k_d  = scan_k_q + 1'b1;
          scan_w_d  = (scan_w_q + 1'b1) & wmask;
          mem_raddr = (scan_w_q + 1'b1) & wmask;
        end
      end
      S_RRD: begin
        if (ro_cpu_q == nc) begin
          state_d = S_RFIN;
        end else begin
          reserved_d[sel] = carry_a;
          active_d[sel]   = 64'd0;
          ro_a_d          = carry_a & mask64;
          if (carry_a != 64'd0) begin
            mem_raddr = WI'((carry_a & mask64) >> BitIdxBits);
            state_d   = S_RWR;
          end else begin
            ro_cpu_d = ro_cpu_q + 1'b1;
          end
        end
      end
      S_RWR: begin
        mem_we    = 1'b1;
        mem_waddr = ro_a_q[MAX_ASID_BITS-1:BitIdxBits];
        mem_wdata = mem_rdata | (64'd1 << ro_a_q[BitIdxBits-1:0]);
        ro_cpu_d  = ro_cpu_q + 1'b1;
        state_d   = S_RRD;
      end
      S_RFIN: begin
        for (int c = 0; c < MAX_CPUS; c++) begin
          if (c < int'(nc)) begin
            flush_d[c] = 1'b1;
          end
        end
        gen_d     = gen_q + pool64;
        hint_d    = HintBits'(1);
        mem_raddr = '0;
        scan_w_d  = '0;
        scan_k_d  = '0;
        state_d   = S_SCAN;
      end
      S_FIN: begin
        res_flush_d   = flush_q[sel];
        flush_d[sel]  = 1'b0;
        active_d[sel] = res_ctx_q;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d.new_ctx     = res_ctx_q;
          rsp_d.asid_number = 16'(res_ctx_q & mask64);
          rsp_d.local_flush = res_flush_q;
          rsp_d.rolled_over = res_roll_q;
          rsp_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // config writes; a width write reinitializes the allocator state and clears the map
    if (cfg_we) begin
      unique case (paddr[2])
        RegAsidWide: begin
          asid_wide_d = pwdata[0];
          gen_d       = pwdata[0] ? (WideMask + 64'd1) : (NarrowMask + 64'd1);
          hint_d      = HintBits'(1);
          for (int c = 0; c < MAX_CPUS; c++) begin
            active_d[c]   = 64'd0;
            reserved_d[c] = 64'd0;
          end
          flush_d = '0;
          clr_d   = '0;
          state_d = S_CLR;
        end
        RegCpuCount: begin
          cpu_count_d = pwdata[3:0];
        end
        default: begin
          cpu_count_d = cpu_count_q;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      asid_wide_q <= 1'b1;
      cpu_count_q <= 4'd1;
      gen_q       <= WideMask + 64'd1;
      hint_q      <= HintBits'(1);
      for (int c = 0; c < MAX_CPUS; c++) begin
        active_q[c]   <= 64'd0;
        reserved_q[c] <= 64'd0;
      end
      flush_q     <= '0;
      clr_q       <= '0;
      scan_w_q    <= '0;
      scan_k_q    <= '0;
      ro_cpu_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      asid_wide_q <= asid_wide_d;
      cpu_count_q <= cpu_count_d;
      gen_q       <= gen_d;
      hint_q      <= hint_d;
      active_q    <= active_d;
      reserved_q  <= reserved_d;
      flush_q     <= flush_d;
      clr_q       <= clr_d;
      scan_w_q    <= scan_w_d;
      scan_k_q    <= scan_k_d;
      ro_cpu_q    <= ro_cpu_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q        <= in_d;
    rsp_q       <= rsp_d;
    res_ctx_q   <= res_ctx_d;
    res_flush_q <= res_flush_d;
    res_roll_q  <= res_roll_d;
    ro_a_q      <= ro_a_d;
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      RegAsidWide: prdata = 32'(asid_wide_q);
      RegCpuCount: prdata = 32'(cpu_count_q);
      default:     prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== sv/asidga_map_ram.sv =====
// Used-ASID bitmap storage: one 64-bit word per 64 ASIDs.
// One write port, one read port, registered read data. Uses asidga_pkg.
module asidga_map_ram import asidga_pkg::*; #(
  parameter int unsigned AW = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [WordBits-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [WordBits-1:0] rdata_o
);

  logic [WordBits-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== tb/sv/asid_generation_allocator_tb.sv =====
// Self-checking testbench for the ASID generation allocator.
// Depends on asidga_pkg and asid_generation_allocator; drives context switches
// and the config port; checks each response against typed values or a predictor.
`timescale 1ns / 100ps

module asid_generation_allocator_tb;
  import asidga_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned NumProcs   = 64;
  localparam int unsigned HoldCycles = 3000;

  // request kinds used by the random part
  typedef enum int {KindReuse, KindFresh, KindNoise, KindStale} req_kind_e;

  typedef struct {
    logic [2:0]  cpu;
    logic [63:0] ctx;
    bit          typed;
    asidga_rsp_t rsp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        req_valid_i = 1'b0;
  logic        req_ready_o;
  asidga_req_t req_i = '0;
  logic        rsp_valid_o;
  logic        rsp_ready_i = 1'b0;
  asidga_rsp_t rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  asid_generation_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  // allocator shadow state
  bit          used_asid [65536];
  logic [63:0] cur_gen;
  int unsigned alloc_hint;
  logic [63:0] live_ctx [MaxCpus];
  logic [63:0] held_ctx [MaxCpus];
  bit          tlb_owed [MaxCpus];
  bit          wide_mode;
  int unsigned cpu_cfg;

  asidga_rsp_t switch_q [$];
  logic [63:0] proc_ctx [NumProcs];
  int unsigned fails = 0;
  int unsigned cycles = 0;
  bit          hold_rsp = 1'b0;

  function automatic logic [63:0] pool_n();
    return 64'd1 << (wide_mode ? MaxAsidBits : NarrowBits);
  endfunction

  function automatic int unsigned scanned_cpus();
    return (cpu_cfg > MaxCpus) ? MaxCpus : cpu_cfg;
  endfunction

  function automatic void clear_map();
    for (int i = 0; i < 65536; i++) used_asid[i] = 1'b0;
    used_asid[0] = 1'b1;
  endfunction

  function automatic void init_shadow();
    clear_map();
    cur_gen = pool_n();
    alloc_hint = 1;
    for (int c = 0; c < MaxCpus; c++) begin
      live_ctx[c] = '0;
      held_ctx[c] = '0;
      tlb_owed[c] = 1'b0;
    end
  endfunction

  // first clear bit from start up, then wrap to 1; pool size when full
  function automatic logic [63:0] scan_free(input logic [63:0] start);
    logic [63:0] n;
    n = pool_n();
    for (logic [63:0] i = start; i < n; i++) if (!used_asid[i]) return i;
    for (logic [63:0] i = 1; i < start && i < n; i++) if (!used_asid[i]) return i;
    return n;
  endfunction

  function automatic void start_generation();
    logic [63:0] a;
    clear_map();
    for (int c = 0; c < scanned_cpus(); c++) begin
      a = live_ctx[c];
      live_ctx[c] = '0;
      if (a == 0) a = held_ctx[c];
      held_ctx[c] = a;
      if (a != 0) used_asid[a & (pool_n() - 1)] = 1'b1;
    end
    for (int c = 0; c < scanned_cpus(); c++) tlb_owed[c] = 1'b1;
    cur_gen += pool_n();
    alloc_hint = 1;
  endfunction

  function automatic logic [63:0] fresh_context(input logic [63:0] old, output bit rolled);
    logic [63:0] mask, renewed, a;
    bit          hit;
    mask = pool_n() - 1;
    rolled = 1'b0;
    hit = 1'b0;
    if (old != 0) begin
      renewed = cur_gen | (old & mask);
      for (int c = 0; c < scanned_cpus(); c++) begin
        if (held_ctx[c] == old) begin
          held_ctx[c] = renewed;
          hit = 1'b1;
        end
      end
      if (hit) return renewed;
      if (!used_asid[old & mask]) begin
        used_asid[old & mask] = 1'b1;
        return renewed;
      end
    end
    a = scan_free(64'(alloc_hint));
    if (a == pool_n()) begin
      start_generation();
      rolled = 1'b1;
      a = scan_free(1) & mask;
    end
    used_asid[a] = 1'b1;
    alloc_hint = int'((a + 1) & 64'h1FFFF);
    return cur_gen | a;
  endfunction

  function automatic asidga_rsp_t switch_context(input asidga_req_t r);
    asidga_rsp_t o;
    logic [63:0] mask, ctx;
    int unsigned cpu;
    bit          flush, rolled;
    mask = pool_n() - 1;
    ctx = r.process_ctx;
    cpu = r.cpu_index;
    flush = 1'b0;
    rolled = 1'b0;
    if (live_ctx[cpu] != 0 && ((ctx ^ cur_gen) & ~mask) == 0) begin
      live_ctx[cpu] = ctx;
    end else begin
      if ((ctx & ~mask) != cur_gen) ctx = fresh_context(ctx, rolled);
      if (tlb_owed[cpu]) begin
        tlb_owed[cpu] = 1'b0;
        flush = 1'b1;
      end
      live_ctx[cpu] = ctx;
    end
    o.new_ctx = ctx;
    o.asid_number = 16'(ctx & mask);
    o.local_flush = flush;
    o.rolled_over = rolled;
    return o;
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegAsidWide) begin
      wide_mode = val[0];
      init_shadow();
      for (int p = 0; p < NumProcs; p++) proc_ctx[p] = '0;
    end else begin
      cpu_cfg = val[3:0];
    end
  endtask

  // offer one request, starting at a falling edge; returns the predicted response
  task automatic send_switch(input logic [2:0] cpu, input logic [63:0] ctx,
                             output asidga_rsp_t pred);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= '{cpu_index: cpu, process_ctx: ctx};
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    pred = switch_context('{cpu_index: cpu, process_ctx: ctx});
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (switch_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_switches(input int unsigned count);
    asidga_rsp_t pred;
    req_kind_e   kind;
    int unsigned p, slot;
    logic [63:0] ctx;
    for (int unsigned n = 0; n < count; n++) begin
      p = $urandom_range(99);
      slot = $urandom_range(NumProcs - 1);
      kind = (p < 45) ? KindReuse : (p < 80) ? KindFresh : (p < 90) ? KindNoise : KindStale;
      case (kind)
        KindReuse: ctx = proc_ctx[slot];
        KindFresh: ctx = '0;
        KindNoise: ctx = {$urandom, $urandom};
        default: begin
          ctx = proc_ctx[slot] - ($urandom_range(1) ? pool_n() : 64'd0);
          if ($urandom_range(1)) ctx = (ctx & (pool_n() - 1)) | (64'($urandom) << 24);
        end
      endcase
      if (n == count / 3) hold_rsp = 1'b1;
      if (n == 2 * count / 3) begin
        // sender pauses until the block is empty
        req_valid_i <= 1'b0;
        while (switch_q.size() != 0) @(negedge clk_i);
      end
      send_switch(3'($urandom_range(7)), ctx, pred);
      switch_q.push_back(pred);
      if (kind != KindNoise) proc_ctx[slot] = pred.new_ctx;
    end
  endtask

  // response side: random stalls plus one long hold-off on request
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (hold_rsp) begin
      hold_rsp <= 1'b0;
      stall_left = HoldCycles;
    end else if (stall_left == 0 && $urandom_range(3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      rsp_ready_i <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready_i <= 1'b1;
    end
  end

  // response checker
  always @(posedge clk_i) begin
    asidga_rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (switch_q.size() == 0) begin
        $error("unexpected response %h", rsp_o);
        fails++;
      end else begin
        want = switch_q.pop_front();
        if (rsp_o.new_ctx !== want.new_ctx) begin
          $error("new_ctx: expected %h, got %h", want.new_ctx, rsp_o.new_ctx);
          fails++;
        end
        if (rsp_o.asid_number !== want.asid_number) begin
          $error("asid_number: expected %h, got %h", want.asid_number, rsp_o.asid_number);
          fails++;
        end
        if (rsp_o.local_flush !== want.local_flush) begin
          $error("local_flush: expected %b, got %b", want.local_flush, rsp_o.local_flush);
          fails++;
        end
        if (rsp_o.rolled_over !== want.rolled_over) begin
          $error("rolled_over: expected %b, got %b", want.rolled_over, rsp_o.rolled_over);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows [$];
    asidga_rsp_t pred;
    wide_mode = 1'b1;
    cpu_cfg = 1;
    init_shadow();
    for (int p = 0; p < NumProcs; p++) proc_ctx[p] = '0;

    // directed: after reset 64K pool, generation 0x10000, one CPU scanned
    rows.push_back('{3'd0, 64'h0, 1'b1, '{64'h10001, 16'h0001, 1'b0, 1'b0}});
    rows.push_back('{3'd0, 64'h10001, 1'b1, '{64'h10001, 16'h0001, 1'b0, 1'b0}});
    rows.push_back('{3'd7, '1, 1'b1, '{64'h1FFFF, 16'hFFFF, 1'b0, 1'b0}});
    // current generation with ASID zero is kept
    rows.push_back('{3'd1, 64'h10000, 1'b1, '{64'h10000, 16'h0000, 1'b0, 1'b0}});
    rows.push_back('{3'd1, 64'h20005, 1'b1, '{64'h10005, 16'h0005, 1'b0, 1'b0}});
    // stale context with ASID zero gets a fresh number
    rows.push_back('{3'd2, 64'hF0000, 1'b0, '0});
    rows.push_back('{3'd3, 64'h8000_0000_0000_0000, 1'b0, '0});
    rows.push_back('{3'd4, 64'h0000_0000_0000_FFFF, 1'b0, '0});
    rows.push_back('{3'd5, 64'h10005, 1'b0, '0});
    rows.push_back('{3'd6, 64'h5555_AAAA_5555_AAAA, 1'b0, '0});
    rows.push_back('{3'd7, 64'h0, 1'b0, '0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      send_switch(rows[i].cpu, rows[i].ctx, pred);
      switch_q.push_back(rows[i].typed ? rows[i].rsp : pred);
    end
    random_switches(120);
    drain();

    // narrow pool, all CPUs: rollovers come quickly
    cfg_write(RegCpuCount, 32'd8);
    cfg_write(RegAsidWide, 32'd0);
    random_switches(400);
    drain();
    cfg_write(RegCpuCount, 32'd3);
    random_switches(250);
    drain();
    cfg_write(RegCpuCount, 32'd15);
    random_switches(150);
    drain();
    cfg_write(RegCpuCount, 32'd0);
    cfg_write(RegAsidWide, 32'd0);
    random_switches(120);
    drain();
    cfg_write(RegCpuCount, 32'd8);
    cfg_write(RegAsidWide, 32'd1);
    random_switches(100);
    drain();

    repeat (50) @(posedge clk_i);
    if (fails == 0 && switch_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/asidga_pkg.sv
sv/asidga_map_ram.sv
sv/asid_generation_allocator.sv
tb/sv/asid_generation_allocator_tb.sv
